// ----- rtl/slt_pkg.sv -----
// Shared types and constants for the sorted list table.
// Used by the cell, the core and the port checker; depends on nothing.
package slt_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  localparam int unsigned OP_W  = 3;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned POS_W = 4;
  localparam int unsigned ST_W  = 2;
  localparam int unsigned LEN_W = 5;

  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 3'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
  localparam logic [OP_W-1:0] OP_READ   = 3'd3;
  localparam logic [OP_W-1:0] OP_SEARCH = 3'd4;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
  localparam logic [ST_W-1:0] ST_NOINDEX  = 2'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

  typedef enum logic [1:0] {
    CMD_HOLD  = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_LEFT  = 2'd2,
    CMD_RIGHT = 2'd3
  } slt_cmd_e;

  typedef struct packed {
    logic     cmp_en;
    slt_cmd_e cmd;
  } slt_ctl_t;

endpackage

// ----- rtl/slt_cell.sv -----
// One entry of the list: holds a value, registers its compare flags
// against a broadcast key and moves data to or from its neighbors. Uses slt_pkg.
module slt_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  slt_pkg::slt_ctl_t                ctl_i,
  input  logic signed [slt_pkg::VAL_W-1:0] key_i,
  input  logic signed [slt_pkg::VAL_W-1:0] new_val_i,
  input  logic signed [slt_pkg::VAL_W-1:0] left_val_i,
  input  logic signed [slt_pkg::VAL_W-1:0] right_val_i,
  output logic signed [slt_pkg::VAL_W-1:0] val_o,
  output logic                             ge_o,
  output logic                             eq_o
);

  logic signed [slt_pkg::VAL_W-1:0] val_q, val_d;
  logic                             ge_q, eq_q;

  always_comb begin
    case (ctl_i.cmd)
      slt_pkg::CMD_LOAD:  val_d = new_val_i;
      slt_pkg::CMD_LEFT:  val_d = left_val_i;
      slt_pkg::CMD_RIGHT: val_d = right_val_i;
      default:            val_d = val_q;
    endcase
  end

  // stored value needs no reset: entries above the count are never read
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ge_q <= 1'b0;
      eq_q <= 1'b0;
    end else if (ctl_i.cmp_en) begin
      ge_q <= (val_q >= key_i);
      eq_q <= (val_q == key_i);
    end
  end

  assign val_o = val_q;
  assign ge_o  = ge_q;
  assign eq_o  = eq_q;

endmodule

// ----- rtl/sorted_list_table_core.sv -----
// Sorted list table top level: a row of slt_cell entries plus the sequencer
// that picks positions and issues moves. Uses slt_pkg and slt_cell.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid/in_ready   | operation, item_value, position_in
//   out     | output    | out_valid/out_ready | status, position_out, value_out, list_length
//
// The accept edge latches an item and registers every cell's compare
// flags; the FIND state then picks the position and moves the cells.
// No new item is accepted while one is in the FIND state.
// Reset empties the list at once; no clearing pass is needed.
// While a result waits on out_ready, no further item is accepted.
module sorted_list_table_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [slt_pkg::OP_W-1:0]           operation_i,
  input  logic signed [slt_pkg::VAL_W-1:0]   item_value_i,
  input  logic [slt_pkg::POS_W-1:0]          position_in_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [slt_pkg::ST_W-1:0]           status_o,
  output logic [slt_pkg::POS_W-1:0]          position_out_o,
  output logic signed [slt_pkg::VAL_W-1:0]   value_out_o,
  output logic [slt_pkg::LEN_W-1:0]          list_length_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_FIND = 1'b1;

  logic state_q, state_d;
  logic in_fire;

  logic [slt_pkg::OP_W-1:0]         op_q;
  logic signed [slt_pkg::VAL_W-1:0] op_val_q;
  logic [slt_pkg::POS_W-1:0]        op_pos_q;
  logic [slt_pkg::CNT_W-1:0]        count_q, count_d;

  logic                             out_valid_q, out_valid_d;
  logic [slt_pkg::ST_W-1:0]         status_q, status_d;
  logic [slt_pkg::POS_W-1:0]        pos_q, pos_d;
  logic signed [slt_pkg::VAL_W-1:0] value_q, value_d;

  logic signed [slt_pkg::VAL_W-1:0] cell_val [slt_pkg::DEPTH];
  logic [slt_pkg::DEPTH-1:0]        ge_flag, eq_flag, live;
  slt_pkg::slt_ctl_t                ctl [slt_pkg::DEPTH];

  logic                             ge_found, eq_found, pos_ok, full;
  logic [slt_pkg::CNT_W-1:0]        ge_idx, eq_idx, ins_idx, req_pos;
  logic signed [slt_pkg::VAL_W-1:0] rd_val;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  genvar g;
  generate
    for (g = 0; g < int'(slt_pkg::DEPTH); g++) begin : g_cell
      logic signed [slt_pkg::VAL_W-1:0] left_v, right_v;
      if (g == 0) begin : g_first
        assign left_v = op_val_q;
      end else begin : g_mid_l
        assign left_v = cell_val[g-1];
      end
      if (g == int'(slt_pkg::DEPTH) - 1) begin : g_last
        assign right_v = cell_val[g];
      end else begin : g_mid_r
        assign right_v = cell_val[g+1];
      end
      slt_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .ctl_i       (ctl[g]),
        .key_i       (item_value_i),
        .new_val_i   (op_val_q),
        .left_val_i  (left_v),
        .right_val_i (right_v),
        .val_o       (cell_val[g]),
        .ge_o        (ge_flag[g]),
        .eq_o        (eq_flag[g])
      );
      assign live[g] = slt_pkg::CNT_W'(g) < count_q;
    end
  endgenerate

  // lowest matching entry among the live ones
  always_comb begin
    ge_found = 1'b0;
    eq_found = 1'b0;
    ge_idx   = '0;
    eq_idx   = '0;
    for (int k = int'(slt_pkg::DEPTH) - 1; k >= 0; k--) begin
      if (ge_flag[k] && live[k]) begin
        ge_found = 1'b1;
        ge_idx   = slt_pkg::CNT_W'(k);
      end
      if (eq_flag[k] && live[k]) begin
        eq_found = 1'b1;
        eq_idx   = slt_pkg::CNT_W'(k);
      end
    end
  end

  assign full    = count_q == slt_pkg::CNT_W'(slt_pkg::DEPTH);
  assign ins_idx = ge_found ? ge_idx : count_q;
  assign req_pos = slt_pkg::CNT_W'(op_pos_q);
  assign pos_ok  = req_pos < count_q;
  assign rd_val  = cell_val[slt_pkg::IDX_W'(op_pos_q)];

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    pos_d       = pos_q;
    value_d     = value_q;
    for (int k = 0; k < int'(slt_pkg::DEPTH); k++) begin
      ctl[k].cmp_en = in_fire;
      ctl[k].cmd    = slt_pkg::CMD_HOLD;
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_FIND;
        end
      end
      S_FIND: begin
        state_d     = S_IDLE;
        out_valid_d = 1'b1;
        status_d    = slt_pkg::ST_OK;
        pos_d       = '0;
        value_d     = '0;
        case (op_q) inside
          slt_pkg::OP_INSERT, slt_pkg::OP_APPEND: begin
            if (full) begin
              status_d = slt_pkg::ST_FULL;
              value_d  = op_val_q;
            end else begin
              value_d = op_val_q;
              count_d = count_q + 1'b1;
              if (op_q == slt_pkg::OP_INSERT) begin
                pos_d = slt_pkg::POS_W'(ins_idx);
                for (int k = 0; k < int'(slt_pkg::DEPTH); k++) begin
                  if (slt_pkg::CNT_W'(k) == ins_idx) begin
                    ctl[k].cmd = slt_pkg::CMD_LOAD;
                  end else if (slt_pkg::CNT_W'(k) > ins_idx) begin
                    ctl[k].cmd = slt_pkg::CMD_LEFT;
                  end
                end
              end else begin
                pos_d = slt_pkg::POS_W'(count_q);
                for (int k = 0; k < int'(slt_pkg::DEPTH); k++) begin
                  if (slt_pkg::CNT_W'(k) == count_q) begin
                    ctl[k].cmd = slt_pkg::CMD_LOAD;
                  end
                end
              end
            end
          end
          slt_pkg::OP_DELETE: begin
            if (pos_ok) begin
              pos_d   = op_pos_q;
              value_d = rd_val;
              count_d = count_q - 1'b1;
              for (int k = 0; k < int'(slt_pkg::DEPTH); k++) begin
                if (slt_pkg::CNT_W'(k) >= req_pos) begin
                  ctl[k].cmd = slt_pkg::CMD_RIGHT;
                end
              end
            end else begin
              status_d = slt_pkg::ST_NOINDEX;
            end
          end
          slt_pkg::OP_READ: begin
            if (pos_ok) begin
              pos_d   = op_pos_q;
              value_d = rd_val;
            end else begin
              status_d = slt_pkg::ST_NOINDEX;
            end
          end
          slt_pkg::OP_SEARCH: begin
            if (eq_found) begin
              pos_d   = slt_pkg::POS_W'(eq_idx);
              value_d = op_val_q;
            end else begin
              status_d = slt_pkg::ST_NOTFOUND;
            end
          end
          default: ;
        endcase
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q     <= operation_i;
      op_val_q <= item_value_i;
      op_pos_q <= position_in_i;
    end
    status_q <= status_d;
    pos_q    <= pos_d;
    value_q  <= value_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign position_out_o = pos_q;
  assign value_out_o    = value_q;
  assign list_length_o  = slt_pkg::LEN_W'(count_q);

endmodule

// ----- rtl/slt_checker.sv -----
// Port-level checks for the sorted list table, bound to the top level.
// Uses slt_pkg.
module slt_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic [slt_pkg::ST_W-1:0]         status_o,
  input logic [slt_pkg::POS_W-1:0]        position_out_o,
  input logic signed [slt_pkg::VAL_W-1:0] value_out_o,
  input logic [slt_pkg::LEN_W-1:0]        list_length_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before it was taken");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted while previous one still in work");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> list_length_o <= slt_pkg::LEN_W'(slt_pkg::DEPTH))
    else $error("list length beyond depth");

  a_pos_zero_on_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != slt_pkg::ST_OK |-> position_out_o == '0)
    else $error("position set on a failed item");

  a_val_zero_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == slt_pkg::ST_NOINDEX || status_o == slt_pkg::ST_NOTFOUND)
    |-> value_out_o == '0)
    else $error("value set on a missed item");

endmodule

bind sorted_list_table_core slt_checker u_slt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .status_o       (status_o),
  .position_out_o (position_out_o),
  .value_out_o    (value_out_o),
  .list_length_o  (list_length_o)
);
